>>> design/stoi_pkg.sv
// Package for the string-to-integer parser: parse phases, character codes,
// register indexes and the character classification functions.
// No dependencies.
`timescale 1ns / 1ps

package stoi_pkg;

    localparam int MAX_LEN_DEFAULT = 4096;

    localparam int CFG_DATA_W = 32;
    localparam int CFG_ADDR_W = 3;
    localparam int BASE_W     = 6;
    localparam int VALUE_W    = 64;

    localparam logic [BASE_W-1:0] BASE_RESET = 6'd10;
    localparam logic [BASE_W-1:0] BASE_AUTO  = 6'd0;
    localparam logic [BASE_W-1:0] BASE_OCT   = 6'd8;
    localparam logic [BASE_W-1:0] BASE_DEC   = 6'd10;
    localparam logic [BASE_W-1:0] BASE_HEX   = 6'd16;
    localparam logic [BASE_W-1:0] BASE_MIN   = 6'd2;
    localparam logic [BASE_W-1:0] BASE_MAX   = 6'd36;

    localparam logic REG_NUMBER_BASE = 1'b0;

    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;
    localparam logic [7:0] CH_LC_A  = 8'h61;
    localparam logic [7:0] CH_LC_Z  = 8'h7a;
    localparam logic [7:0] CH_UC_A  = 8'h41;
    localparam logic [7:0] CH_UC_Z  = 8'h5a;
    localparam logic [7:0] CH_LC_X  = 8'h78;
    localparam logic [7:0] CH_UC_X  = 8'h58;
    localparam logic [7:0] CH_MINUS = 8'h2d;
    localparam logic [7:0] CH_PLUS  = 8'h2b;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_LF    = 8'h0a;
    localparam logic [7:0] CH_VT    = 8'h0b;
    localparam logic [7:0] CH_FF    = 8'h0c;
    localparam logic [7:0] CH_CR    = 8'h0d;

    typedef enum logic [2:0] {
        PH_SKIP_WS,
        PH_AFTER_SGN,
        PH_AFTER_0,
        PH_AFTER_X,
        PH_DIGITS
    } phase_t;

    typedef struct packed {
        logic              ok;
        logic [BASE_W-1:0] val;
    } digit_t;

    function automatic digit_t char_value(input logic [7:0] c);
        digit_t d;
        d.ok  = 1'b0;
        d.val = '0;
        if (c >= CH_ZERO && c <= CH_NINE)
        begin
            d.ok  = 1'b1;
            d.val = BASE_W'(c - CH_ZERO);
        end
        else if (c >= CH_LC_A && c <= CH_LC_Z)
        begin
            d.ok  = 1'b1;
            d.val = BASE_W'(c - CH_LC_A) + 6'd10;
        end
        else if (c >= CH_UC_A && c <= CH_UC_Z)
        begin
            d.ok  = 1'b1;
            d.val = BASE_W'(c - CH_UC_A) + 6'd10;
        end
        return d;
    endfunction

    function automatic logic is_white(input logic [7:0] c);
        return (c == CH_SPACE) || (c == CH_TAB) || (c == CH_LF) ||
               (c == CH_CR) || (c == CH_VT) || (c == CH_FF);
    endfunction

endpackage

>>> design/string_to_integer_parser.sv
// Streaming string-to-integer parser with strtol semantics and an APB
// register for the number base. Depends on stoi_pkg.
//
//   Channel   Direction   Contents
//   s_*       in          one byte of the string per transfer, tlast ends it
//   m_*       out         parsed value, digit flag and end offset
//   APB       in/out      number_base register at byte address 0
//
// Each byte is registered on input, then one step of the parser (one
// 64 by 6 bit multiply-add) runs between that register and the result
// register, so a new byte is taken in every cycle unless the result side
// stalls. A stall on the result side holds only a byte that would produce
// a result; other bytes keep flowing. Reset restores the base to 10 and
// clears the parse state.
`timescale 1ns / 1ps

module string_to_integer_parser
    import stoi_pkg::*;
#(
    parameter int MAX_LEN = MAX_LEN_DEFAULT,
    localparam int POS_W  = $clog2(MAX_LEN + 1),
    localparam int OUT_W  = ((VALUE_W + POS_W + 7) / 8) * 8
)
(
    input  logic                  clk,
    input  logic                  rst_n,

    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [7:0]            s_tdata,   // ch[7:0]
    input  logic                  s_tlast,

    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [OUT_W-1:0]      m_tdata,   // value[63:0], end_offset, zero pad
    output logic                  m_tuser,   // any_digits

    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [CFG_ADDR_W-1:0] paddr,
    input  logic [CFG_DATA_W-1:0] pwdata,
    output logic [CFG_DATA_W-1:0] prdata,
    output logic                  pready
);

    localparam logic [POS_W:0] MAX_POS = (POS_W + 1)'(MAX_LEN);

    logic [BASE_W-1:0]  base_cfg_reg;

    logic               in_valid_reg;
    logic [7:0]         in_ch_reg;
    logic               in_last_reg;

    phase_t             phase_reg, phase_next;
    logic [VALUE_W-1:0] acc_reg, acc_next;
    logic               neg_reg, neg_next;
    logic               seen_reg, seen_next;
    logic [BASE_W-1:0]  base_act_reg, base_act_next;
    logic [POS_W-1:0]   pos_reg, pos_next;
    logic [POS_W-1:0]   end_reg, end_next;
    logic               done_reg;

    logic               out_valid_reg;
    logic [VALUE_W-1:0] out_value_reg;
    logic               out_any_reg;
    logic [POS_W-1:0]   out_end_reg;

    logic               stop;
    logic               emit;
    logic               advance;
    logic [VALUE_W-1:0] res_value;
    logic [POS_W-1:0]   res_end;

    function automatic logic [POS_W-1:0] end_after(input logic [POS_W-1:0] p);
        logic [POS_W:0] e;
        e = {1'b0, p} + 1'b1;
        if (e > MAX_POS)
        begin
            e = MAX_POS;
        end
        return e[POS_W-1:0];
    endfunction

    // Configuration port.
    assign pready = 1'b1;
    always_comb
    begin
        prdata = '0;
        if (paddr[2] == REG_NUMBER_BASE)
        begin
            prdata = CFG_DATA_W'(base_cfg_reg);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            base_cfg_reg <= BASE_RESET;
        end
        else if (psel && penable && pwrite && pready && paddr[2] == REG_NUMBER_BASE)
        begin
            base_cfg_reg <= pwdata[BASE_W-1:0];
        end
    end

    // Parser step for the registered byte.
    always_comb
    begin
        digit_t             dig;
        logic               first_sig;
        logic               try_digit;
        logic               digit_ok;
        logic [BASE_W-1:0]  base_use;
        logic [VALUE_W-1:0] prod;

        dig           = char_value(in_ch_reg);
        first_sig     = 1'b0;
        try_digit     = 1'b0;
        digit_ok      = 1'b0;
        base_use      = base_act_reg;
        prod          = '0;
        stop          = 1'b0;
        phase_next    = phase_reg;
        acc_next      = acc_reg;
        neg_next      = neg_reg;
        seen_next     = seen_reg;
        base_act_next = base_act_reg;
        end_next      = end_reg;
        pos_next      = end_after(pos_reg);

        if (!done_reg)
        begin
            unique case (phase_reg)
                PH_SKIP_WS:
                begin
                    if (is_white(in_ch_reg))
                    begin
                        phase_next = PH_SKIP_WS;
                    end
                    else if (in_ch_reg == CH_PLUS || in_ch_reg == CH_MINUS)
                    begin
                        neg_next   = (in_ch_reg == CH_MINUS);
                        phase_next = PH_AFTER_SGN;
                    end
                    else
                    begin
                        first_sig = 1'b1;
                    end
                end
                PH_AFTER_SGN:
                begin
                    first_sig = 1'b1;
                end
                PH_AFTER_0:
                begin
                    if (in_ch_reg == CH_LC_X || in_ch_reg == CH_UC_X)
                    begin
                        phase_next = PH_AFTER_X;
                    end
                    else
                    begin
                        phase_next = PH_DIGITS;
                        try_digit  = 1'b1;
                    end
                end
                PH_AFTER_X:
                begin
                    if (dig.ok && dig.val < BASE_HEX)
                    begin
                        base_use   = BASE_HEX;
                        phase_next = PH_DIGITS;
                        try_digit  = 1'b1;
                    end
                    else
                    begin
                        stop = 1'b1;
                    end
                end
                PH_DIGITS:
                begin
                    try_digit = 1'b1;
                end
                default:
                begin
                    try_digit = 1'b1;
                end
            endcase

            if (first_sig)
            begin
                if (in_ch_reg == CH_ZERO &&
                    (base_cfg_reg == BASE_AUTO || base_cfg_reg == BASE_HEX))
                begin
                    base_act_next = (base_cfg_reg == BASE_AUTO) ? BASE_OCT : BASE_HEX;
                    acc_next      = '0;
                    seen_next     = 1'b1;
                    end_next      = end_after(pos_reg);
                    phase_next    = PH_AFTER_0;
                end
                else
                begin
                    base_use   = (base_cfg_reg == BASE_AUTO) ? BASE_DEC : base_cfg_reg;
                    phase_next = PH_DIGITS;
                    try_digit  = 1'b1;
                end
            end

            if (try_digit)
            begin
                base_act_next = base_use;
                digit_ok = (base_use >= BASE_MIN) && (base_use <= BASE_MAX) &&
                           dig.ok && (dig.val < base_use);
                if (digit_ok)
                begin
                    prod      = acc_reg * {{(VALUE_W-BASE_W){1'b0}}, base_use};
                    acc_next  = prod + {{(VALUE_W-BASE_W){1'b0}}, dig.val};
                    seen_next = 1'b1;
                    end_next  = end_after(pos_reg);
                end
                else
                begin
                    stop = 1'b1;
                end
            end
        end
    end

    // Result formed from the updated parse state.
    always_comb
    begin
        emit      = !done_reg && (stop || in_last_reg);
        res_value = '0;
        res_end   = '0;
        if (seen_next)
        begin
            res_value = neg_next ? (VALUE_W'(0) - acc_next) : acc_next;
            res_end   = end_next;
        end
    end

    assign advance  = in_valid_reg && !(emit && out_valid_reg && !m_tready);
    assign s_tready = !in_valid_reg || advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (s_tready)
        begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
        begin
            in_ch_reg   <= s_tdata;
            in_last_reg <= s_tlast;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg    <= PH_SKIP_WS;
            acc_reg      <= '0;
            neg_reg      <= 1'b0;
            seen_reg     <= 1'b0;
            base_act_reg <= '0;
            pos_reg      <= '0;
            end_reg      <= '0;
            done_reg     <= 1'b0;
        end
        else if (advance)
        begin
            if (in_last_reg)
            begin
                phase_reg    <= PH_SKIP_WS;
                acc_reg      <= '0;
                neg_reg      <= 1'b0;
                seen_reg     <= 1'b0;
                base_act_reg <= '0;
                pos_reg      <= '0;
                end_reg      <= '0;
                done_reg     <= 1'b0;
            end
            else
            begin
                phase_reg    <= phase_next;
                acc_reg      <= acc_next;
                neg_reg      <= neg_next;
                seen_reg     <= seen_next;
                base_act_reg <= base_act_next;
                pos_reg      <= pos_next;
                end_reg      <= end_next;
                done_reg     <= done_reg | emit;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (advance && emit)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance && emit)
        begin
            out_value_reg <= res_value;
            out_any_reg   <= seen_next;
            out_end_reg   <= res_end;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = OUT_W'({out_end_reg, out_value_reg});
    assign m_tuser  = out_any_reg;

endmodule

>>> tb/stoi_checker.sv
// Checker for the string-to-integer parser: watches the byte, result and APB
// channels, predicts each parse and compares it with the block's result.
// Depends on stoi_pkg.
`timescale 1ns / 1ps

module stoi_checker
    import stoi_pkg::*;
#(
    parameter int MAX_LEN = MAX_LEN_DEFAULT,
    localparam int POS_W  = $clog2(MAX_LEN + 1),
    localparam int OUT_W  = ((VALUE_W + POS_W + 7) / 8) * 8
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  s_tvalid,
    input  logic                  s_tready,
    input  logic [7:0]            s_tdata,
    input  logic                  s_tlast,
    input  logic                  m_tvalid,
    input  logic                  m_tready,
    input  logic [OUT_W-1:0]      m_tdata,
    input  logic                  m_tuser,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [CFG_ADDR_W-1:0] paddr,
    input  logic [CFG_DATA_W-1:0] pwdata,
    input  logic                  pready,
    output int                    mismatches,
    output int                    pending_results,
    output int                    results_seen
);

    localparam logic [CFG_ADDR_W-1:0] BASE_ADDR = CFG_ADDR_W'(4 * int'(REG_NUMBER_BASE));

    typedef struct {
        logic [VALUE_W-1:0] value;
        logic               any_digits;
        logic [POS_W-1:0]   end_offset;
    } parse_t;

    parse_t             parsed_q[$];
    parse_t             want;
    logic [BASE_W-1:0]  number_base;
    phase_t             phase;
    logic [VALUE_W-1:0] acc;
    logic               negative;
    logic               seen_digit;
    logic [BASE_W-1:0]  active_base;
    int                 byte_pos;
    logic               waiting_last;
    int                 end_saved;

    function automatic int digit_of(input logic [7:0] c);
        if (c >= CH_ZERO && c <= CH_NINE)
            return int'(c - CH_ZERO);
        if (c >= CH_LC_A && c <= CH_LC_Z)
            return int'(c - CH_LC_A) + 10;
        if (c >= CH_UC_A && c <= CH_UC_Z)
            return int'(c - CH_UC_A) + 10;
        return -1;
    endfunction

    function automatic int past(input int p);
        return (p + 1 > MAX_LEN) ? MAX_LEN : p + 1;
    endfunction

    task automatic clear_parse();
        phase        = PH_SKIP_WS;
        acc          = '0;
        negative     = 1'b0;
        seen_digit   = 1'b0;
        active_base  = '0;
        byte_pos     = 0;
        waiting_last = 1'b0;
        end_saved    = 0;
    endtask

    task automatic take_digit(input logic [7:0] c, input int p, output logic ok);
        int d;
        d  = digit_of(c);
        ok = 1'b0;
        if (active_base >= BASE_MIN && active_base <= BASE_MAX && d >= 0 &&
            d < int'(active_base))
        begin
            acc        = acc * VALUE_W'(active_base) + VALUE_W'(d);
            seen_digit = 1'b1;
            end_saved  = past(p);
            ok         = 1'b1;
        end
    endtask

    // First byte after whitespace and sign: a leading zero may open a prefix.
    task automatic start_number(input logic [7:0] c, input int p, output logic stop);
        logic ok;
        stop = 1'b0;
        if (c == CH_ZERO && (number_base == BASE_AUTO || number_base == BASE_HEX))
        begin
            active_base = (number_base == BASE_AUTO) ? BASE_OCT : BASE_HEX;
            acc         = '0;
            seen_digit  = 1'b1;
            end_saved   = past(p);
            phase       = PH_AFTER_0;
        end
        else
        begin
            active_base = (number_base == BASE_AUTO) ? BASE_DEC : number_base;
            phase       = PH_DIGITS;
            take_digit(c, p, ok);
            stop = !ok;
        end
    endtask

    task automatic predict_byte(input logic [7:0] c, input logic is_last);
        int     p;
        int     d;
        logic   stop;
        logic   ok;
        parse_t r;
        p    = byte_pos;
        stop = 1'b0;
        if (!waiting_last)
        begin
            case (phase)
                PH_SKIP_WS:
                begin
                    if (c == CH_PLUS || c == CH_MINUS)
                    begin
                        negative = (c == CH_MINUS);
                        phase    = PH_AFTER_SGN;
                    end
                    else if (!(c == CH_SPACE || c == CH_TAB || c == CH_LF || c == CH_CR ||
                               c == CH_VT || c == CH_FF))
                    begin
                        start_number(c, p, stop);
                    end
                end
                PH_AFTER_SGN:
                    start_number(c, p, stop);
                PH_AFTER_0:
                begin
                    if (c == CH_LC_X || c == CH_UC_X)
                        phase = PH_AFTER_X;
                    else
                    begin
                        phase = PH_DIGITS;
                        take_digit(c, p, ok);
                        stop = !ok;
                    end
                end
                PH_AFTER_X:
                begin
                    d = digit_of(c);
                    if (d >= 0 && d < 16)
                    begin
                        active_base = BASE_HEX;
                        phase       = PH_DIGITS;
                        take_digit(c, p, ok);
                        stop = !ok;
                    end
                    else
                        stop = 1'b1;
                end
                default:
                begin
                    take_digit(c, p, ok);
                    stop = !ok;
                end
            endcase
            if (stop || is_last)
            begin
                r.value      = !seen_digit ? '0 : (negative ? -acc : acc);
                r.any_digits = seen_digit;
                r.end_offset = seen_digit ? POS_W'(end_saved) : '0;
                parsed_q.push_back(r);
                waiting_last = 1'b1;
            end
        end
        byte_pos = past(p);
        if (is_last)
            clear_parse();
    endtask

    task automatic report_mismatch(input string what, input logic [63:0] exp_v,
                                   input logic [63:0] got_v);
        $display("MISMATCH at %0t: %s: expected 0x%h, got 0x%h", $time, what, exp_v, got_v);
        mismatches++;
    endtask

    initial
    begin
        mismatches      = 0;
        pending_results = 0;
        results_seen    = 0;
        number_base     = BASE_RESET;
        clear_parse();
    end

    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            parsed_q.delete();
            number_base = BASE_RESET;
            clear_parse();
        end
        else
        begin
            if (m_tvalid && m_tready)
            begin
                results_seen++;
                if (parsed_q.size() == 0)
                    report_mismatch("result transfer with no parse outstanding", '0,
                                    m_tdata[VALUE_W-1:0]);
                else
                begin
                    want = parsed_q.pop_front();
                    if (m_tdata[VALUE_W-1:0] !== want.value)
                        report_mismatch("value", want.value, m_tdata[VALUE_W-1:0]);
                    if (m_tuser !== want.any_digits)
                        report_mismatch("any_digits", 64'(want.any_digits), 64'(m_tuser));
                    if (m_tdata[VALUE_W +: POS_W] !== want.end_offset)
                        report_mismatch("end_offset", 64'(want.end_offset),
                                        64'(m_tdata[VALUE_W +: POS_W]));
                end
            end
            if (psel && penable && pwrite && pready && paddr == BASE_ADDR)
                number_base = pwdata[BASE_W-1:0];
            if (s_tvalid && s_tready)
                predict_byte(s_tdata, s_tlast);
        end
        pending_results = parsed_q.size();
    end

endmodule

>>> tb/tb_top.sv
// Top of the string-to-integer parser testbench: clock, reset, byte stimulus,
// result-side stalls and APB base writes, with the verdict from stoi_checker.
// Depends on stoi_pkg, string_to_integer_parser and stoi_checker.
`timescale 1ns / 1ps

module tb_top;
    import stoi_pkg::*;

    localparam int MAX_LEN = MAX_LEN_DEFAULT;
    localparam int POS_W   = $clog2(MAX_LEN + 1);
    localparam int OUT_W   = ((VALUE_W + POS_W + 7) / 8) * 8;

    localparam logic [CFG_ADDR_W-1:0] BASE_ADDR = CFG_ADDR_W'(4 * int'(REG_NUMBER_BASE));
    localparam logic [BASE_W-1:0] BASE_BAD_LOW  = 6'd1;
    localparam logic [BASE_W-1:0] BASE_BAD_HIGH = 6'd63;

    typedef logic [7:0] bytes_t[$];

    logic                  clk;
    logic                  rst_n;
    logic                  s_tvalid;
    logic                  s_tready;
    logic [7:0]            s_tdata;    // ch[7:0]
    logic                  s_tlast;
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    logic [OUT_W-1:0]      m_tdata;    // value[63:0], end_offset[76:64], zero pad
    logic                  m_tuser;    // any_digits
    logic                  psel;
    logic                  penable;
    logic                  pwrite;
    logic [CFG_ADDR_W-1:0] paddr;
    logic [CFG_DATA_W-1:0] pwdata;
    logic [CFG_DATA_W-1:0] prdata;
    logic                  pready;

    int                    mismatches;
    int                    pending_results;
    int                    results_seen;

    int                    src_idle;
    int                    sink_idle;
    logic                  hold_arm;
    logic                  long_hold = 1'b0;
    logic [BASE_W-1:0]     cur_base;
    int                    bytes_sent;
    int                    strings_sent;
    int                    base_writes;

    string_to_integer_parser #(.MAX_LEN(MAX_LEN)) u_top (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    stoi_checker #(.MAX_LEN(MAX_LEN)) u_checker (
        .clk             (clk),
        .rst_n           (rst_n),
        .s_tvalid        (s_tvalid),
        .s_tready        (s_tready),
        .s_tdata         (s_tdata),
        .s_tlast         (s_tlast),
        .m_tvalid        (m_tvalid),
        .m_tready        (m_tready),
        .m_tdata         (m_tdata),
        .m_tuser         (m_tuser),
        .psel            (psel),
        .penable         (penable),
        .pwrite          (pwrite),
        .paddr           (paddr),
        .pwdata          (pwdata),
        .pready          (pready),
        .mismatches      (mismatches),
        .pending_results (pending_results),
        .results_seen    (results_seen)
    );

    always
    begin
        clk = 1'b0;
        #10;
        clk = 1'b1;
        #10;
    end

    always @(negedge clk)
        m_tready <= !long_hold && (sink_idle == 0 || $urandom_range(99) >= sink_idle);

    // One long stall on the result side while bytes keep coming.
    initial
    begin
        wait (hold_arm);
        repeat (20) @(negedge clk);
        long_hold <= 1'b1;
        repeat (400) @(negedge clk);
        long_hold <= 1'b0;
    end

    initial
    begin
        #5_000_000;
        $display("tb_top NOT OK");
        $finish;
    end

    task automatic put_byte(input logic [7:0] c, input logic is_last);
        @(negedge clk);
        while (src_idle > 0 && $urandom_range(99) < src_idle)
        begin
            s_tvalid <= 1'b0;
            @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= c;
        s_tlast  <= is_last;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        bytes_sent++;
    endtask

    task automatic put_seq(input bytes_t s);
        for (int i = 0; i < s.size(); i++)
            put_byte(s[i], i == s.size() - 1);
        strings_sent++;
    endtask

    task automatic write_base(input logic [BASE_W-1:0] b);
        @(negedge clk);
        s_tvalid <= 1'b0;
        wait (pending_results == 0);
        repeat (4) @(negedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= BASE_ADDR;
        pwdata  <= CFG_DATA_W'(b);
        @(negedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        @(negedge clk);
        psel     <= 1'b0;
        penable  <= 1'b0;
        pwrite   <= 1'b0;
        cur_base = b;
        base_writes++;
    endtask

    task automatic random_string(input logic [BASE_W-1:0] b);
        bytes_t s;
        int     eff;
        int     n;
        int     k;
        s = {};
        if ($urandom_range(99) < 20)
        begin
            n = $urandom_range(1, 6);
            repeat (n) s.push_back(8'($urandom_range(255)));
        end
        else
        begin
            repeat ($urandom_range(0, 2))
            begin
                case ($urandom_range(5))
                    0: s.push_back(CH_SPACE);
                    1: s.push_back(CH_TAB);
                    2: s.push_back(CH_LF);
                    3: s.push_back(CH_CR);
                    4: s.push_back(CH_VT);
                    default: s.push_back(CH_FF);
                endcase
            end
            case ($urandom_range(2))
                1: s.push_back(CH_PLUS);
                2: s.push_back(CH_MINUS);
                default: ;
            endcase
            eff = (b == BASE_AUTO) ? int'(BASE_DEC) : int'(b);
            if ((b == BASE_AUTO || b == BASE_HEX) && $urandom_range(1) == 1)
            begin
                s.push_back(CH_ZERO);
                eff = (b == BASE_AUTO) ? int'(BASE_OCT) : int'(BASE_HEX);
                if ($urandom_range(1) == 1)
                begin
                    s.push_back($urandom_range(1) ? CH_LC_X : CH_UC_X);
                    eff = int'(BASE_HEX);
                end
            end
            if (eff < int'(BASE_MIN) || eff > int'(BASE_MAX))
                eff = int'(BASE_DEC);
            n = ($urandom_range(9) == 0) ? $urandom_range(20, 40) : $urandom_range(0, 12);
            repeat (n)
            begin
                k = $urandom_range(eff - 1);
                if (k < 10)
                    s.push_back(CH_ZERO + 8'(k));
                else
                    s.push_back(($urandom_range(1) ? CH_LC_A : CH_UC_A) + 8'(k - 10));
            end
            repeat ($urandom_range(0, 3)) s.push_back(8'($urandom_range(255)));
        end
        if (s.size() == 0)
            s.push_back(8'($urandom_range(255)));
        put_seq(s);
    endtask

    initial
    begin
        logic [BASE_W-1:0] nb;
        int                start;
        rst_n        = 1'b0;
        s_tvalid     = 1'b0;
        s_tdata      = '0;
        s_tlast      = 1'b0;
        psel         = 1'b0;
        penable      = 1'b0;
        pwrite       = 1'b0;
        paddr        = '0;
        pwdata       = '0;
        hold_arm     = 1'b0;
        src_idle     = 36;
        sink_idle    = 70;
        cur_base     = BASE_RESET;
        bytes_sent   = 0;
        strings_sent = 0;
        base_writes  = 0;
        repeat (12) @(negedge clk);
        rst_n = 1'b1;

        // Directed strings, starting at the reset base of ten.
        put_seq('{CH_TAB, CH_VT, CH_FF, CH_CR, CH_LF, CH_SPACE, CH_MINUS, "9"});
        put_seq('{CH_PLUS, "5", 8'h00, 8'hff});
        put_seq('{CH_MINUS});
        write_base(BASE_AUTO);
        put_seq('{"0", "x", "1", "F"});
        put_seq('{"0", "1", "7"});
        put_seq('{"0", "X", "g"});
        write_base(BASE_HEX);
        put_seq('{"0", "X"});
        write_base(BASE_MAX);
        put_seq('{"z", "Z"});
        write_base(BASE_MIN);
        put_seq('{"1", "0", "2"});
        write_base(BASE_BAD_HIGH);
        put_seq('{"5"});
        write_base(BASE_BAD_LOW);
        put_seq('{"0"});
        write_base(BASE_DEC);

        for (int mode = 0; mode < 3; mode++)
        begin
            src_idle  = (mode == 0) ? 36 : (mode == 1) ? 70 : 0;
            sink_idle = (mode == 0) ? 70 : (mode == 1) ? 36 : 0;
            if (mode == 2)
                hold_arm = 1'b1;
            start = bytes_sent;
            while (bytes_sent - start < 384)
            begin
                if (strings_sent % 12 == 0)
                begin
                    case ($urandom_range(9))
                        0: nb = BASE_AUTO;
                        1: nb = BASE_HEX;
                        2: nb = BASE_DEC;
                        3: nb = BASE_MIN;
                        4: nb = BASE_MAX;
                        5: nb = BASE_OCT;
                        6: nb = $urandom_range(1) ? BASE_BAD_LOW : BASE_BAD_HIGH;
                        7: nb = BASE_W'($urandom_range(37, 62));
                        default: nb = BASE_W'($urandom_range(2, 36));
                    endcase
                    write_base(nb);
                end
                random_string(cur_base);
            end
        end

        @(negedge clk);
        s_tvalid <= 1'b0;
        wait (pending_results == 0);
        repeat (10) @(negedge clk);
        $display("Sent %0d bytes in %0d strings across %0d base writes; %0d results checked.",
                 bytes_sent, strings_sent, base_writes, results_seen);
        $display("Covered whitespace, signs, hex and octal prefixes, bad bases, overflow %s",
                 "and long output stalls.");
        if (mismatches == 0 && pending_results == 0)
            $display("tb_top OK");
        else
            $display("tb_top NOT OK");
        $finish;
    end

endmodule
